>>> rtl/core/rpr_pkg.sv
// ----------------------------------------------------------------------------
// Rotary position rotator package
// Shared payload types, register codes, angle constants and the constant
// functions that build the exponent root table.
// ----------------------------------------------------------------------------
`default_nettype none

package rpr_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int E_W      = 21;   // exponent, Q5.16
    localparam int FRAC_W   = 16;
    localparam int F_W      = 31;   // 2^-e in Q30
    localparam int THETA_W  = 42;
    localparam int ANG_W    = 19;   // reduced angle before sign
    localparam int Z_W      = 20;   // signed CORDIC angle
    localparam int XY_W     = 32;   // CORDIC x/y, Q29

    localparam logic [ANG_W-1:0]      ANG_TWO_PI   = 19'd411775;
    localparam logic signed [Z_W-1:0] Z_TWO_PI     = 20'sd411775;
    localparam logic signed [Z_W-1:0] Z_PI         = 20'sd205887;
    localparam logic signed [Z_W-1:0] Z_HALF_PI    = 20'sd102944;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd326016437;

    // Reciprocal of two pi for the angle reduction: floor(2^42 / 411775).
    localparam logic [23:0] TWO_PI_RECIP = 24'd10680703;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [Z_W-1:0] ATAN_Q16 [ATAN_ENTRIES] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
        20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
    };

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_POS_OFFSET = 2'd0,
        REG_ROT_DIMS   = 2'd1,
        REG_LOG2_BASE  = 2'd2,
        REG_FREQ_SCALE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                       mode;
        logic [15:0]                seq_index;
        logic [5:0]                 pair_index;
        logic signed [SAMPLE_W-1:0] x_first;
        logic signed [SAMPLE_W-1:0] x_second;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] y_first;
        logic signed [SAMPLE_W-1:0] y_second;
    } t_out;

    // Per-transaction sideband carried down the pipeline.
    typedef struct packed {
        logic                       mode;
        logic                       pass;
        logic [15:0]                seq_index;
        logic signed [SAMPLE_W-1:0] x_first;
        logic signed [SAMPLE_W-1:0] x_second;
    } t_tag;

    // Integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Root factor 2^(-2^-k) in Q30.
    function automatic logic [63:0] exp_root(input int k);
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int i = 1; i < k; i++) begin
            r = isqrt64(r << 30);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rpr_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces a few quotient bits per stage; the numerator must be below the
// divisor shifted by the quotient width. A sideband word rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_div #(
    parameter int NUM_W  = 28,
    parameter int DEN_W  = 8,
    parameter int Q_BITS = 21,
    parameter int STEPS  = 3,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [Q_BITS-1:0]      o_quot,
    output logic [NUM_W-1:0]       o_rem,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int W    = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;
    localparam int NSTG = (Q_BITS + STEPS - 1) / STEPS;

    logic [W-1:0]      r_rem  [NSTG];
    logic [Q_BITS-1:0] r_q    [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];
    logic [NSTG-1:0]   r_vld;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [W-1:0]      rem_in;
        logic [Q_BITS-1:0] q_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [W-1:0]      n_rem;
        logic [Q_BITS-1:0] n_q;

        if (s == 0) begin : g_first
            assign rem_in  = W'(i_num);
            assign q_in    = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign q_in    = r_q[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        // Trial subtract for each quotient bit handled by this stage.
        always_comb begin
            int          bp;
            logic [W-1:0] trial;
            n_rem = rem_in;
            n_q   = q_in;
            for (int j = 0; j < STEPS; j++) begin
                bp    = Q_BITS - 1 - s * STEPS - j;
                trial = '0;
                if (bp >= 0) begin
                    trial = W'(i_den) << bp;
                    if (n_rem >= trial) begin
                        n_rem = n_rem - trial;
                        n_q   = n_q | (Q_BITS'(1) << bp);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_q[s]    <= n_q;
            r_side[s] <= side_in;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_quot  = r_q[NSTG-1];
    assign o_rem   = r_rem[NSTG-1][NUM_W-1:0];
    assign o_side  = r_side[NSTG-1];

endmodule

`default_nettype wire

>>> rtl/core/rpr_exp2.sv
// ----------------------------------------------------------------------------
// Negative power of two
// Builds 2^-e in Q30 from a Q5.16 exponent: one truncating multiply by a
// root factor per fraction bit, then a shift by the integer part.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_exp2 #(
    parameter int SIDE_W = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [rpr_pkg::E_W-1:0] i_e,
    input  wire logic [SIDE_W-1:0]       i_side,
    output logic                         o_valid,
    output logic [rpr_pkg::F_W-1:0]      o_f,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int NK = rpr_pkg::FRAC_W;

    logic [rpr_pkg::F_W-1:0] r_m    [NK];
    logic [rpr_pkg::E_W-1:0] r_e    [NK];
    logic [SIDE_W-1:0]       r_side [NK];
    logic [NK-1:0]           r_vld;

    logic [rpr_pkg::F_W-1:0] r_f;
    logic [SIDE_W-1:0]       r_fside;
    logic                    r_fvld;

    for (genvar k = 0; k < NK; k++) begin : g_stg
        localparam logic [29:0] ROOT = 30'(rpr_pkg::exp_root(k + 1));
        logic [rpr_pkg::F_W-1:0] m_in;
        logic [rpr_pkg::E_W-1:0] e_in;
        logic [SIDE_W-1:0]       side_in;
        logic                    vld_in;
        logic [60:0]             prod;
        logic [rpr_pkg::F_W-1:0] n_m;

        if (k == 0) begin : g_first
            assign m_in    = rpr_pkg::F_W'(1) << 30;
            assign e_in    = i_e;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign m_in    = r_m[k-1];
            assign e_in    = r_e[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // Most significant fraction bit first, as the root chain runs.
        assign prod = {30'b0, m_in} * {31'b0, ROOT};
        assign n_m  = e_in[NK-1-k] ? prod[60:30] : m_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_m[k]    <= n_m;
            r_e[k]    <= e_in;
            r_side[k] <= side_in;
        end
    end

    // Integer part of the exponent is a plain right shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= 1'b0;
        end else begin
            r_fvld <= r_vld[NK-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f     <= r_m[NK-1] >> r_e[NK-1][rpr_pkg::E_W-1:NK];
        r_fside <= r_side[NK-1];
    end

    assign o_valid = r_fvld;
    assign o_f     = r_f;
    assign o_side  = r_fside;

    // The factor never exceeds one in Q30.
    a_f_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fvld |-> (r_f <= (rpr_pkg::F_W'(1) << 30)))
        else $error("exp2 result above one");

endmodule

`default_nettype wire

>>> rtl/core/rpr_cordic.sv
// ----------------------------------------------------------------------------
// Rotation-mode CORDIC
// One micro-rotation per stage, starting from the gain constant on x.
// Final x and y are cosine and sine in Q29.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_cordic #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic signed [rpr_pkg::Z_W-1:0]       i_z,
    input  wire logic [SIDE_W-1:0]                    i_side,
    output logic                                      o_valid,
    output logic signed [rpr_pkg::XY_W-1:0]           o_cos,
    output logic signed [rpr_pkg::XY_W-1:0]           o_sin,
    output logic [SIDE_W-1:0]                         o_side
);

    logic signed [rpr_pkg::XY_W-1:0] r_x    [STAGES];
    logic signed [rpr_pkg::XY_W-1:0] r_y    [STAGES];
    logic signed [rpr_pkg::Z_W-1:0]  r_z    [STAGES];
    logic [SIDE_W-1:0]               r_side [STAGES];
    logic [STAGES-1:0]               r_vld;

    for (genvar k = 0; k < STAGES; k++) begin : g_stg
        logic signed [rpr_pkg::XY_W-1:0] x_in;
        logic signed [rpr_pkg::XY_W-1:0] y_in;
        logic signed [rpr_pkg::Z_W-1:0]  z_in;
        logic [SIDE_W-1:0]               side_in;
        logic                            vld_in;
        logic signed [rpr_pkg::XY_W-1:0] dx;
        logic signed [rpr_pkg::XY_W-1:0] dy;

        if (k == 0) begin : g_first
            assign x_in    = rpr_pkg::CORDIC_GAIN;
            assign y_in    = '0;
            assign z_in    = i_z;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign y_in    = r_y[k-1];
            assign z_in    = r_z[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        // Rotate toward zero residual angle.
        always_ff @(posedge i_clk) begin
            if (!z_in[rpr_pkg::Z_W-1]) begin
                r_x[k] <= x_in - dx;
                r_y[k] <= y_in + dy;
                r_z[k] <= z_in - rpr_pkg::ATAN_Q16[k];
            end else begin
                r_x[k] <= x_in + dx;
                r_y[k] <= y_in - dy;
                r_z[k] <= z_in + rpr_pkg::ATAN_Q16[k];
            end
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_cos   = r_x[STAGES-1];
    assign o_sin   = r_y[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/rotary_position_rotator.sv
// ----------------------------------------------------------------------------
// Rotary position rotator
// Rotates one element pair per cycle by its position angle, with angle
// generation, range reduction, CORDIC and rounding all pipelined.
//
//   Channel   Signals                        Direction  Handshake
//   item      start, busy, i_in              in         start && !busy
//   result    o_valid, o_out                 out        strobe, one cycle
//   config    psel..pready, paddr, pwdata    in/out     APB write, pready=1
//
// The pipeline runs through the exponent divider, the sixteen root multiplies,
// the angle product, the angle reduction, the fold, the CORDIC and rotation.
// One transaction is accepted every cycle; busy is always low.
// Reset is synchronous and active low; it clears the pipeline valid bits
// and loads the register defaults. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_position_rotator #(
    parameter int MAX_DIMS      = 128,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rpr_pkg::t_in  i_in,
    output logic               o_valid,
    output rpr_pkg::t_out      o_out,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int          DCLAMP = (MAX_DIMS > 255) ? 255 : MAX_DIMS;
    localparam logic [7:0]  D_MAX  = 8'(DCLAMP);
    localparam int          TAG_W  = $bits(rpr_pkg::t_tag);
    localparam int          SW     = rpr_pkg::SAMPLE_W;

    // Configuration registers.
    logic [15:0] r_pos_offset;
    logic [7:0]  r_rot_dims;
    logic [15:0] r_log2_base;
    logic [15:0] r_freq_scale;
    rpr_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = rpr_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_offset <= 16'd0;
            r_rot_dims   <= 8'd128;
            r_log2_base  <= 16'd27213;
            r_freq_scale <= 16'd256;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                rpr_pkg::REG_POS_OFFSET: r_pos_offset <= pwdata[15:0];
                rpr_pkg::REG_ROT_DIMS:   r_rot_dims   <= pwdata[7:0];
                rpr_pkg::REG_LOG2_BASE:  r_log2_base  <= pwdata[15:0];
                rpr_pkg::REG_FREQ_SCALE: r_freq_scale <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rpr_pkg::REG_POS_OFFSET: prdata = {16'b0, r_pos_offset};
            rpr_pkg::REG_ROT_DIMS:   prdata = {24'b0, r_rot_dims};
            rpr_pkg::REG_LOG2_BASE:  prdata = {16'b0, r_log2_base};
            rpr_pkg::REG_FREQ_SCALE: prdata = {16'b0, r_freq_scale};
            default:                 prdata = '0;
        endcase
    end

    // Rotated width clamped to the head size.
    logic [7:0] w_dims;
    assign w_dims = (r_rot_dims > D_MAX) ? D_MAX : r_rot_dims;

    // Input stage: pass-through decision and exponent numerator.
    logic          r_s1_vld;
    logic [27:0]   r_s1_num;
    rpr_pkg::t_tag r_s1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_num           <= {22'(r_log2_base * i_in.pair_index), 6'b0};
        r_s1_tag.mode      <= i_in.mode;
        r_s1_tag.pass      <= {2'b0, i_in.pair_index} >= {1'b0, w_dims[7:1]};
        r_s1_tag.seq_index <= i_in.seq_index;
        r_s1_tag.x_first   <= i_in.x_first;
        r_s1_tag.x_second  <= i_in.x_second;
    end

    // Exponent e = base * 64 * pair / D.
    logic                    w_e_vld;
    logic [rpr_pkg::E_W-1:0] w_e;
    logic [TAG_W-1:0]        w_e_side;

    rpr_div #(
        .NUM_W (28),
        .DEN_W (8),
        .Q_BITS(rpr_pkg::E_W),
        .STEPS (3),
        .SIDE_W(TAG_W)
    ) u_div_e (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_s1_vld),
        .i_num  (r_s1_num),
        .i_den  (w_dims),
        .i_side (r_s1_tag),
        .o_valid(w_e_vld),
        .o_quot (w_e),
        .o_rem  (),
        .o_side (w_e_side)
    );

    // Frequency factor 2^-e.
    logic                    w_f_vld;
    logic [rpr_pkg::F_W-1:0] w_f;
    logic [TAG_W-1:0]        w_f_side;

    rpr_exp2 #(
        .SIDE_W(TAG_W)
    ) u_exp2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_e_vld),
        .i_e    (w_e),
        .i_side (w_e_side),
        .o_valid(w_f_vld),
        .o_f    (w_f),
        .o_side (w_f_side)
    );

    // Angle product: position times scale, then split multiply by the factor.
    rpr_pkg::t_tag           w_f_tag;
    logic                    r_ta_vld, r_tb_vld, r_tc_vld;
    logic [32:0]             r_ta_p;
    logic [rpr_pkg::F_W-1:0] r_ta_f;
    rpr_pkg::t_tag           r_ta_tag, r_tb_tag, r_tc_tag;
    logic [47:0]             r_tb_lo;
    logic [46:0]             r_tb_hi;
    logic [rpr_pkg::THETA_W-1:0] r_tc_theta;
    logic [63:0]             w_sum;
    logic [16:0]             w_pos;

    assign w_f_tag = rpr_pkg::t_tag'(w_f_side);
    assign w_pos   = 17'(r_pos_offset) + 17'(w_f_tag.seq_index);
    assign w_sum   = 64'(r_tb_lo) + {r_tb_hi, 17'b0} + (64'd1 << 21);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta_vld <= 1'b0;
            r_tb_vld <= 1'b0;
            r_tc_vld <= 1'b0;
        end else begin
            r_ta_vld <= w_f_vld;
            r_tb_vld <= r_ta_vld;
            r_tc_vld <= r_tb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ta_p     <= 33'(w_pos) * 33'(r_freq_scale);
        r_ta_f     <= w_f;
        r_ta_tag   <= w_f_tag;
        r_tb_lo    <= 48'(r_ta_p[16:0]) * 48'(r_ta_f);
        r_tb_hi    <= 47'(r_ta_p[32:17]) * 47'(r_ta_f);
        r_tb_tag   <= r_ta_tag;
        r_tc_theta <= w_sum[63:22];
        r_tc_tag   <= r_tb_tag;
    end

    // Reduce the angle modulo two pi. A reciprocal multiply on the top bits
    // gives a quotient that is low by at most two; the back-multiplied
    // remainder then needs at most one corrective subtract of one or two turns.
    logic                        r_ma_vld, r_mb_vld, r_mc_vld;
    logic [22:0]                 r_ma_q;
    logic [20:0]                 r_ma_theta;
    rpr_pkg::t_tag               r_ma_tag, r_mb_tag, r_mc_tag;
    logic [20:0]                 r_mb_rem;
    logic [rpr_pkg::ANG_W-1:0]   r_mc_rem;
    logic [46:0]                 w_ma_prod;
    logic [20:0]                 w_mb_back;
    logic [20:0]                 w_mc_rem;

    assign w_ma_prod = 47'(r_tc_theta[40:18]) * 47'(rpr_pkg::TWO_PI_RECIP);
    assign w_mb_back = 21'(r_ma_q[20:0] * 21'(rpr_pkg::ANG_TWO_PI));

    always_comb begin
        if (r_mb_rem >= {1'b0, rpr_pkg::ANG_TWO_PI, 1'b0}) begin
            w_mc_rem = r_mb_rem - {1'b0, rpr_pkg::ANG_TWO_PI, 1'b0};
        end else if (r_mb_rem >= {2'b0, rpr_pkg::ANG_TWO_PI}) begin
            w_mc_rem = r_mb_rem - {2'b0, rpr_pkg::ANG_TWO_PI};
        end else begin
            w_mc_rem = r_mb_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma_vld <= 1'b0;
            r_mb_vld <= 1'b0;
            r_mc_vld <= 1'b0;
        end else begin
            r_ma_vld <= r_tc_vld;
            r_mb_vld <= r_ma_vld;
            r_mc_vld <= r_mb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma_q     <= w_ma_prod[46:24];
        r_ma_theta <= r_tc_theta[20:0];
        r_ma_tag   <= r_tc_tag;
        r_mb_rem   <= r_ma_theta - w_mb_back;
        r_mb_tag   <= r_ma_tag;
        r_mc_rem   <= w_mc_rem[rpr_pkg::ANG_W-1:0];
        r_mc_tag   <= r_mb_tag;
    end

    // Fold into [-pi/2, pi/2]; the half-turn flips cosine and sine.
    logic                            r_fd_vld;
    logic signed [rpr_pkg::Z_W-1:0]  r_fd_z;
    logic [TAG_W:0]                  r_fd_side;
    logic signed [rpr_pkg::Z_W-1:0]  w_z0, w_z1;
    logic                            w_neg;

    always_comb begin
        w_z0 = $signed({1'b0, r_mc_rem});
        if (w_z0 > rpr_pkg::Z_PI) begin
            w_z0 = w_z0 - rpr_pkg::Z_TWO_PI;
        end
        w_z1  = w_z0;
        w_neg = 1'b0;
        if (w_z0 > rpr_pkg::Z_HALF_PI) begin
            w_z1  = w_z0 - rpr_pkg::Z_PI;
            w_neg = 1'b1;
        end else if (w_z0 < -rpr_pkg::Z_HALF_PI) begin
            w_z1  = w_z0 + rpr_pkg::Z_PI;
            w_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fd_vld <= 1'b0;
        end else begin
            r_fd_vld <= r_mc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fd_z    <= w_z1;
        r_fd_side <= {w_neg, r_mc_tag};
    end

    // Cosine and sine.
    logic                            w_c_vld;
    logic signed [rpr_pkg::XY_W-1:0] w_cos, w_sin;
    logic [TAG_W:0]                  w_c_side;

    rpr_cordic #(
        .STAGES(CORDIC_STAGES),
        .SIDE_W(TAG_W + 1)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_fd_vld),
        .i_z    (r_fd_z),
        .i_side (r_fd_side),
        .o_valid(w_c_vld),
        .o_cos  (w_cos),
        .o_sin  (w_sin),
        .o_side (w_c_side)
    );

    // Rotation: sign fix, products, then round and saturate.
    logic                            r_r0_vld, r_r1_vld, r_out_vld;
    logic signed [rpr_pkg::XY_W-1:0] r_r0_c, r_r0_s;
    rpr_pkg::t_tag                   r_r0_tag, r_r1_tag;
    logic signed [47:0]              r_p1c, r_p2s, r_p1s, r_p2c;
    rpr_pkg::t_out                   r_out;
    logic signed [48:0]              w_a1, w_a2;

    function automatic logic signed [SW-1:0] round_sat(input logic signed [48:0] a);
        logic signed [48:0] t;
        t = (a + 49'sd268435456) >>> 29;
        if (t > 49'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -49'sd32768) begin
            return 16'sh8000;
        end
        return t[SW-1:0];
    endfunction

    always_comb begin
        if (!r_r1_tag.mode) begin
            w_a1 = 49'(r_p1c) - 49'(r_p2s);
            w_a2 = 49'(r_p1s) + 49'(r_p2c);
        end else begin
            w_a1 = 49'(r_p1c) + 49'(r_p2s);
            w_a2 = 49'(r_p2c) - 49'(r_p1s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0_vld  <= 1'b0;
            r_r1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_r0_vld  <= w_c_vld;
            r_r1_vld  <= r_r0_vld;
            r_out_vld <= r_r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0_c   <= w_c_side[TAG_W] ? -w_cos : w_cos;
        r_r0_s   <= w_c_side[TAG_W] ? -w_sin : w_sin;
        r_r0_tag <= rpr_pkg::t_tag'(w_c_side[TAG_W-1:0]);
        r_p1c    <= r_r0_tag.x_first * r_r0_c;
        r_p2s    <= r_r0_tag.x_second * r_r0_s;
        r_p1s    <= r_r0_tag.x_first * r_r0_s;
        r_p2c    <= r_r0_tag.x_second * r_r0_c;
        r_r1_tag <= r_r0_tag;
        if (r_r1_tag.pass) begin
            r_out.y_first  <= r_r1_tag.x_first;
            r_out.y_second <= r_r1_tag.x_second;
        end else begin
            r_out.y_first  <= round_sat(w_a1);
            r_out.y_second <= round_sat(w_a2);
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    // Reduced angle stays below two pi.
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mc_vld |-> (r_mc_rem < rpr_pkg::ANG_TWO_PI))
        else $error("angle remainder out of range");

    // Folded angle lies within a quarter turn of zero.
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fd_vld |-> (r_fd_z <= rpr_pkg::Z_HALF_PI && r_fd_z >= -rpr_pkg::Z_HALF_PI))
        else $error("folded angle out of range");

    // A pass-through transaction leaves its samples untouched.
    a_pass_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_r1_vld && r_r1_tag.pass) |=>
            (r_out.y_first == $past(r_r1_tag.x_first)
             && r_out.y_second == $past(r_r1_tag.x_second)))
        else $error("pass-through sample changed");

endmodule

`default_nettype wire
